/* rtl/hsb_pkg.sv */
// hsb_pkg: shared widths and sector codes for the hsb to rgb converter
// no dependencies; imported by every rtl file of the block
package hsb_pkg;

    localparam int HUE_W = 16;
    localparam int SV_W  = 17;
    localparam int CH_W  = 8;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef logic [CH_W-1:0] t_chan;

endpackage

/* rtl/hsb_chan_round.sv */
// hsb_chan_round: scales a q.2f term in [0, 1.0] by 255 with half-up rounding
// depends on hsb_pkg
module hsb_chan_round #(
    parameter int FRAC_BITS = 16
) (
    input  logic [2*FRAC_BITS:0]   i_term,
    output hsb_pkg::t_chan         o_chan
);
    import hsb_pkg::*;

    localparam int TW = 2 * FRAC_BITS + CH_W + 1;

    logic [TW-1:0] sum;

    // term * 255 = (term << 8) - term
    assign sum = (TW'(i_term) << CH_W) - TW'(i_term) + (TW'(1) << (2 * FRAC_BITS - 1));
    assign o_chan = sum[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

endmodule

/* rtl/hsb_to_rgb_converter.sv */
// hsb_to_rgb_converter: four-stage pipelined hue, saturation, brightness to rgb
// depends on hsb_pkg and hsb_chan_round
//
// One pixel is taken in every clock cycle; busy never rises. Each result appears
// on o_red_channel, o_green_channel and o_blue_channel with o_strobe high for one
// cycle, once its start transfer has passed the four register stages: sector
// split, saturation products, brightness products, and rounding with channel
// selection. The receiver has no way to hold results off.
module hsb_to_rgb_converter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [hsb_pkg::HUE_W-1:0] i_hue_fraction,
    input  logic [hsb_pkg::SV_W-1:0]  i_saturation_level,
    input  logic [hsb_pkg::SV_W-1:0]  i_brightness_level,
    output logic                      o_strobe,
    output logic [hsb_pkg::CH_W-1:0]  o_red_channel,
    output logic [hsb_pkg::CH_W-1:0]  o_green_channel,
    output logic [hsb_pkg::CH_W-1:0]  o_blue_channel
);
    import hsb_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int CW = (F + 1 > SV_W) ? F + 1 : SV_W;
    localparam logic [F:0]    UNIT   = (F+1)'(1) << F;
    localparam logic [CW-1:0] UNIT_C = CW'(1) << F;

    // valid chain
    logic [3:0] r_vld;
    logic [3:0] n_vld;

    // stage 1
    logic [F-1:0]   hue_m;
    logic [F+2:0]   h6;
    logic [CW-1:0]  sat_c;
    logic [CW-1:0]  val_c;
    t_sector        r_sec1;
    logic [F-1:0]   r_f1;
    logic [F:0]     r_omf1;
    logic [F:0]     r_sat1;
    logic [F:0]     r_val1;

    // stage 2
    logic [2*F:0]   prod_q;
    logic [2*F+1:0] prod_t;
    t_sector        r_sec2;
    logic           r_grey2;
    logic [F:0]     r_fac_p2;
    logic [F:0]     r_fac_q2;
    logic [F:0]     r_fac_t2;
    logic [F:0]     r_val2;

    // stage 3
    logic [2*F+1:0] mul_p;
    logic [2*F+1:0] mul_q;
    logic [2*F+1:0] mul_t;
    t_sector        r_sec3;
    logic           r_grey3;
    logic [2*F:0]   r_term_v3;
    logic [2*F:0]   r_term_p3;
    logic [2*F:0]   r_term_q3;
    logic [2*F:0]   r_term_t3;

    // stage 4
    t_chan          cv;
    t_chan          cp;
    t_chan          cq;
    t_chan          ct;
    t_chan          n_red;
    t_chan          n_green;
    t_chan          n_blue;
    t_chan          r_red;
    t_chan          r_green;
    t_chan          r_blue;

    assign busy  = 1'b0;
    assign n_vld = {r_vld[2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 1: clamp, hue times six, sector and remainder
    assign hue_m = F'(i_hue_fraction);
    assign h6    = (F+3)'(hue_m) * (F+3)'(6);
    assign sat_c = (CW'(i_saturation_level) > UNIT_C) ? UNIT_C : CW'(i_saturation_level);
    assign val_c = (CW'(i_brightness_level) > UNIT_C) ? UNIT_C : CW'(i_brightness_level);

    always_ff @(posedge i_clk) begin
        r_sec1 <= t_sector'(h6[F+2:F]);
        r_f1   <= h6[F-1:0];
        r_omf1 <= UNIT - (F+1)'(h6[F-1:0]);
        r_sat1 <= sat_c[F:0];
        r_val1 <= val_c[F:0];
    end

    // stage 2: saturation products and q.f factors
    assign prod_q = (2*F+1)'(r_sat1) * (2*F+1)'(r_f1);
    assign prod_t = (2*F+2)'(r_sat1) * (2*F+2)'(r_omf1);

    always_ff @(posedge i_clk) begin
        r_sec2   <= r_sec1;
        r_grey2  <= (r_sat1 == '0);
        r_fac_p2 <= UNIT - r_sat1;
        r_fac_q2 <= UNIT - prod_q[2*F:F];
        r_fac_t2 <= UNIT - prod_t[2*F:F];
        r_val2   <= r_val1;
    end

    // stage 3: brightness products
    assign mul_p = (2*F+2)'(r_val2) * (2*F+2)'(r_fac_p2);
    assign mul_q = (2*F+2)'(r_val2) * (2*F+2)'(r_fac_q2);
    assign mul_t = (2*F+2)'(r_val2) * (2*F+2)'(r_fac_t2);

    always_ff @(posedge i_clk) begin
        r_sec3    <= r_sec2;
        r_grey3   <= r_grey2;
        r_term_v3 <= (2*F+1)'(r_val2) << F;
        r_term_p3 <= mul_p[2*F:0];
        r_term_q3 <= mul_q[2*F:0];
        r_term_t3 <= mul_t[2*F:0];
    end

    // stage 4: rounding and channel selection
    hsb_chan_round #(.FRAC_BITS(FRAC_BITS)) u_round_v (.i_term(r_term_v3), .o_chan(cv));
    hsb_chan_round #(.FRAC_BITS(FRAC_BITS)) u_round_p (.i_term(r_term_p3), .o_chan(cp));
    hsb_chan_round #(.FRAC_BITS(FRAC_BITS)) u_round_q (.i_term(r_term_q3), .o_chan(cq));
    hsb_chan_round #(.FRAC_BITS(FRAC_BITS)) u_round_t (.i_term(r_term_t3), .o_chan(ct));

    always_comb begin
        if (r_grey3) begin
            n_red   = cv;
            n_green = cv;
            n_blue  = cv;
        end else begin
            unique case (r_sec3)
                SEC_0: begin
                    n_red = cv; n_green = ct; n_blue = cp;
                end
                SEC_1: begin
                    n_red = cq; n_green = cv; n_blue = cp;
                end
                SEC_2: begin
                    n_red = cp; n_green = cv; n_blue = ct;
                end
                SEC_3: begin
                    n_red = cp; n_green = cq; n_blue = cv;
                end
                SEC_4: begin
                    n_red = ct; n_green = cp; n_blue = cv;
                end
                default: begin
                    n_red = cv; n_green = cp; n_blue = cq;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_strobe        = r_vld[3];
    assign o_red_channel   = r_red;
    assign o_green_channel = r_green;
    assign o_blue_channel  = r_blue;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_strobe)
        else $error("transfer did not produce a result after four cycles");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[2] && r_grey3) |=>
        (o_red_channel == o_green_channel && o_green_channel == o_blue_channel))
        else $error("zero saturation did not give grey");

    a_factors: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_fac_q2 <= UNIT && r_fac_t2 <= UNIT && r_fac_p2 <= UNIT))
        else $error("factor above one");

endmodule

/* tb/sv/hsb_rgb_check_pkg.sv */
// hsb_rgb_check_pkg: expected-color scoreboard for the hsb to rgb converter
// computes each pixel's rgb from its hue, saturation and brightness in fixed point
// depends on hsb_pkg for channel width and sector codes
package hsb_rgb_check_pkg;
    import hsb_pkg::*;

    localparam int FRAC = 16;
    localparam logic [63:0] UNIT = 64'd1 << FRAC;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    class rgb_scoreboard;
        t_rgb expected_colors[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function logic [63:0] clamp_one(logic [63:0] x);
            return (x > UNIT) ? UNIT : x;
        endfunction

        // q.2f term to 0..255, round half up
        function t_chan round_255(logic [63:0] term);
            logic [63:0] scaled;
            scaled = (term * 64'd255 + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
            return scaled[CH_W-1:0];
        endfunction

        function t_rgb convert_hsb(logic [HUE_W-1:0] hue, logic [SV_W-1:0] sat_in,
                                   logic [SV_W-1:0] val_in);
            logic [63:0] sat;
            logic [63:0] val;
            logic [63:0] h6;
            logic [63:0] f;
            logic [63:0] fac_q;
            logic [63:0] fac_t;
            t_chan       cv;
            t_chan       cp;
            t_chan       cq;
            t_chan       ct;
            t_sector     sector;
            t_rgb        rgb;
            sat    = clamp_one(64'(sat_in));
            val    = clamp_one(64'(val_in));
            h6     = (64'(hue) & (UNIT - 64'd1)) * 64'd6;
            sector = t_sector'(h6[FRAC+2:FRAC]);
            f      = h6 & (UNIT - 64'd1);
            fac_q  = UNIT - ((sat * f) >> FRAC);
            fac_t  = UNIT - ((sat * (UNIT - f)) >> FRAC);
            cv     = round_255(val * UNIT);
            cp     = round_255(val * (UNIT - sat));
            cq     = round_255(val * fac_q);
            ct     = round_255(val * fac_t);
            if (sat == 64'd0) begin
                rgb = '{cv, cv, cv};
            end else begin
                case (sector)
                    SEC_0: rgb = '{cv, ct, cp};
                    SEC_1: rgb = '{cq, cv, cp};
                    SEC_2: rgb = '{cp, cv, ct};
                    SEC_3: rgb = '{cp, cq, cv};
                    SEC_4: rgb = '{ct, cp, cv};
                    default: rgb = '{cv, cp, cq};
                endcase
            end
            return rgb;
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void note_pixel(logic [HUE_W-1:0] hue, logic [SV_W-1:0] sat,
                                 logic [SV_W-1:0] val);
            expected_colors.push_back(convert_hsb(hue, sat, val));
        endfunction

        task check_pixel(t_rgb got);
            t_rgb want;
            if (expected_colors.size() == 0) begin
                report("result strobe with no pixel pending");
                return;
            end
            want = expected_colors.pop_front();
            if (got.red !== want.red)
                report($sformatf("red got %0d want %0d", got.red, want.red));
            if (got.green !== want.green)
                report($sformatf("green got %0d want %0d", got.green, want.green));
            if (got.blue !== want.blue)
                report($sformatf("blue got %0d want %0d", got.blue, want.blue));
        endtask

        function int pending();
            return expected_colors.size();
        endfunction
    endclass

endpackage

/* tb/sv/tb_top.sv */
// tb_top: drives pixels into hsb_to_rgb_converter and checks every rgb result
// depends on hsb_pkg, hsb_rgb_check_pkg and the rtl of the block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsb_pkg::*;
    import hsb_rgb_check_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [HUE_W-1:0]  i_hue_fraction;
    logic [SV_W-1:0]   i_saturation_level;
    logic [SV_W-1:0]   i_brightness_level;
    logic              o_strobe;
    logic [CH_W-1:0]   o_red_channel;
    logic [CH_W-1:0]   o_green_channel;
    logic [CH_W-1:0]   o_blue_channel;

    rgb_scoreboard sb;

    hsb_to_rgb_converter uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_hue_fraction     (i_hue_fraction),
        .i_saturation_level (i_saturation_level),
        .i_brightness_level (i_brightness_level),
        .o_strobe           (o_strobe),
        .o_red_channel      (o_red_channel),
        .o_green_channel    (o_green_channel),
        .o_blue_channel     (o_blue_channel)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && start === 1'b1 && busy === 1'b0)
            sb.note_pixel(i_hue_fraction, i_saturation_level, i_brightness_level);
        if (i_rst_n === 1'b1 && o_strobe === 1'b1)
            sb.check_pixel('{o_red_channel, o_green_channel, o_blue_channel});
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SV_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return SV_W'(1 << 16);
            2: return SV_W'($urandom_range(65537, 131071));
            3: return SV_W'($urandom_range(0, 15));
            default: return SV_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // one transfer, then an optional idle stretch with start low
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SV_W-1:0] sat,
                              input logic [SV_W-1:0] val, input int gap);
        start              <= 1'b1;
        i_hue_fraction     <= hue;
        i_saturation_level <= sat;
        i_brightness_level <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    logic [HUE_W-1:0] dir_hue [20] = '{
        16'd0,     16'd10923, 16'd10922, 16'd21845, 16'd21846, 16'd32768, 16'd43690,
        16'd43691, 16'd54612, 16'd54613, 16'd65535, 16'd0,     16'd32768, 16'd4000,
        16'd50000, 16'd30000, 16'd0,     16'd21845, 16'd43690, 16'd32768
    };
    logic [SV_W-1:0] dir_sat [20] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd0,     17'd0,     17'd0,
        17'd131071, 17'd65536, 17'd1,    17'd32768, 17'd65535, 17'd0
    };
    logic [SV_W-1:0] dir_val [20] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536,
        17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd32768, 17'd1,
        17'd131071, 17'd0,     17'd65535, 17'd98304, 17'd65535, 17'd0
    };

    initial begin
        bit idle_free;
        sb                 = new();
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_hue_fraction     = '0;
        i_saturation_level = '0;
        i_brightness_level = '0;
        idle_free          = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sector edges, extremes, grey and above-one levels
        for (int i = 0; i < 20; i++)
            send_pixel(dir_hue[i], dir_sat[i], dir_val[i], pick_gap());

        for (int i = 0; i < 850; i++) begin
            if (i % 100 == 0)
                idle_free = ($urandom_range(0, 3) == 0);
            send_pixel(HUE_W'($urandom), pick_level(), pick_level(),
                       idle_free ? 0 : pick_gap());
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
